@@ hdl/stereo_crossfeed_q28_macros.svh @@
// Assertion macros shared by the crossfeed RTL
`ifndef STEREO_CROSSFEED_Q28_MACROS_SVH
`define STEREO_CROSSFEED_Q28_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/scf_pkg.sv @@
// Shared types, constants and saturating arithmetic for the crossfeed block
package scf_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int Q_SHIFT     = 28;
  localparam int GAIN_BITS   = 29;
  localparam int COEF_BITS   = GAIN_BITS + 1;
  localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
  localparam int SHIFT_BITS  = PROD_BITS - Q_SHIFT;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0]   wide_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic        [GAIN_BITS-1:0]   gain_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  // register indexes
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_POLE = 2'd1;
  localparam logic [1:0] REG_COEF = 2'd2;

  // multiplier operand selection
  localparam logic [1:0] MSEL_G_IN = 2'd0;
  localparam logic [1:0] MSEL_P_LP = 2'd1;
  localparam logic [1:0] MSEL_C_LP = 2'd2;
  localparam logic [1:0] MSEL_C_AP = 2'd3;

  typedef struct packed {
    gain_t gain;
    gain_t pole;
    coef_t coef;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] msel;
    logic       acc_en;
    logic       lp_en;
    logic       dir_en;
    logic       ap_en;
    logic       st_en;
  } cmd_t;

  function automatic sample_t sat_wide(input wide_t v);
    if (v[SAMPLE_BITS] != v[SAMPLE_BITS-1]) begin
      return v[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic sample_t add_sat(input sample_t a, input sample_t b);
    wide_t s;
    s = wide_t'({a[SAMPLE_BITS-1], a}) + wide_t'({b[SAMPLE_BITS-1], b});
    return sat_wide(s);
  endfunction

  function automatic sample_t sub_sat(input sample_t a, input sample_t b);
    wide_t s;
    s = wide_t'({a[SAMPLE_BITS-1], a}) - wide_t'({b[SAMPLE_BITS-1], b});
    return sat_wide(s);
  endfunction

  // arithmetic shift right by Q_SHIFT, then saturate to the sample range
  function automatic sample_t qsat(input prod_t p);
    logic [SHIFT_BITS-1:0]            sh;
    logic [SHIFT_BITS-SAMPLE_BITS:0]  top;
    sh  = p[PROD_BITS-1:Q_SHIFT];
    top = sh[SHIFT_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return sh[SAMPLE_BITS-1:0];
    end
    return sh[SHIFT_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
  endfunction

endpackage

@@ hdl/scf_regs.sv @@
// APB register file for the crossfeed coefficients
module scf_regs import scf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg,
  output logic                 clear
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite;
  // any write to a known register restarts the filters
  assign clear  = wr && (idx == REG_GAIN || idx == REG_POLE || idx == REG_COEF);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN: cfg.gain <= pwdata[GAIN_BITS-1:0];
        REG_POLE: cfg.pole <= pwdata[GAIN_BITS-1:0];
        REG_COEF: cfg.coef <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN: prdata = {{(DATA_BITS-GAIN_BITS){1'b0}}, cfg.gain};
      REG_POLE: prdata = {{(DATA_BITS-GAIN_BITS){1'b0}}, cfg.pole};
      REG_COEF: prdata = {{(DATA_BITS-COEF_BITS){cfg.coef[COEF_BITS-1]}}, cfg.coef};
      default:  prdata = '0;
    endcase
  end

endmodule

@@ hdl/scf_ctrl.sv @@
// Step sequencer for the crossfeed datapath
`include "stereo_crossfeed_q28_macros.svh"

module scf_ctrl import scf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_stall,
  output logic in_stall,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_G    = 3'd1;
  localparam logic [2:0] S_P    = 3'd2;
  localparam logic [2:0] S_LP   = 3'd3;
  localparam logic [2:0] S_CL   = 3'd4;
  localparam logic [2:0] S_AP   = 3'd5;
  localparam logic [2:0] S_CA   = 3'd6;
  localparam logic [2:0] S_ST   = 3'd7;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       hold, done, accept;

  // last step waits while the previous result is still stalled
  assign hold     = out_valid && out_stall;
  assign done     = (state == S_ST) && !hold;
  assign in_stall = !((state == S_IDLE) || done);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd         = '0;
    cmd.msel    = MSEL_G_IN;
    cmd.load_in = accept;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_G;
      end
      S_G: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_G_IN;
        state_next = S_P;
      end
      S_P: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_P_LP;
        cmd.acc_en = 1'b1;
        state_next = S_LP;
      end
      S_LP: begin
        cmd.lp_en  = 1'b1;
        state_next = S_CL;
      end
      S_CL: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_C_LP;
        cmd.dir_en = 1'b1;
        state_next = S_AP;
      end
      S_AP: begin
        cmd.ap_en  = 1'b1;
        state_next = S_CA;
      end
      S_CA: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MSEL_C_AP;
        state_next = S_ST;
      end
      S_ST: begin
        if (done) begin
          cmd.st_en  = 1'b1;
          state_next = accept ? S_G : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (done) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SCF_ASSERT_NOW(a_ready_only_idle_or_done, !in_stall, state == S_IDLE || state == S_ST, "input taken mid-computation")
  `SCF_ASSERT_NEXT(a_hold_keeps_last_step, state == S_ST && hold, state == S_ST, "last step left while result stalled")
  `SCF_ASSERT_NEXT(a_accept_starts, accept, state == S_G, "accepted request did not start")
  `SCF_ASSERT_NEXT(a_done_shows_result, done, out_valid, "finished request not presented")

endmodule

@@ hdl/scf_dp.sv @@
// Two-lane datapath: shared multiplier per channel, filter state, output register
module scf_dp import scf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  cfg_t    cfg,
  input  logic    clear,
  input  sample_t left_in,
  input  sample_t right_in,
  output sample_t left_out,
  output sample_t right_out
);

  sample_t x    [2];
  prod_t   prod [2];
  sample_t acc  [2];
  sample_t lp   [2];
  sample_t dir  [2];
  sample_t ap   [2];
  sample_t apst [2];
  sample_t pq   [2];
  sample_t opnd [2];
  coef_t   coef_sel;

  always_comb begin
    unique case (cmd.msel)
      MSEL_G_IN: coef_sel = coef_t'({1'b0, cfg.gain});
      MSEL_P_LP: coef_sel = coef_t'({1'b0, cfg.pole});
      MSEL_C_LP: coef_sel = cfg.coef;
      MSEL_C_AP: coef_sel = cfg.coef;
      default:   coef_sel = cfg.coef;
    endcase
    for (int l = 0; l < 2; l++) begin
      pq[l] = qsat(prod[l]);
      unique case (cmd.msel)
        MSEL_G_IN: opnd[l] = x[l];
        MSEL_P_LP: opnd[l] = lp[l];
        MSEL_C_LP: opnd[l] = lp[l];
        MSEL_C_AP: opnd[l] = ap[l];
        default:   opnd[l] = x[l];
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x[0] <= left_in;
      x[1] <= right_in;
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.mul_en) prod[l] <= coef_sel * opnd[l];
      if (cmd.acc_en) acc[l]  <= pq[l];
      if (cmd.dir_en) dir[l]  <= sub_sat(x[l], lp[l]);
      if (cmd.ap_en)  ap[l]   <= add_sat(pq[l], apst[l]);
    end
    if (cmd.st_en) begin
      left_out  <= add_sat(dir[0], ap[1]);
      right_out <= add_sat(dir[1], ap[0]);
    end
  end

  // filter state: cleared by reset and by any write to a known register
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (rst || clear) begin
        lp[l]   <= '0;
        apst[l] <= '0;
      end else begin
        if (cmd.lp_en) lp[l]   <= add_sat(acc[l], pq[l]);
        if (cmd.st_en) apst[l] <= sub_sat(lp[l], pq[l]);
      end
    end
  end

endmodule

@@ hdl/stereo_crossfeed_q28.sv @@
// Each channel has one 30x32 multiplier reused for four products per stereo pair,
//   each product registered before its add step.
// A new request is taken in the cycle its predecessor's result is loaded, so the
//   output register decouples the consumer; a stalled result holds only the last step.
// Reset (rst, synchronous) clears coefficients, filter state and all handshake state.
module stereo_crossfeed_q28 import scf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  // input request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              left_in,
  input  sample_t              right_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output sample_t              left_out,
  output sample_t              right_out
);

  cfg_t cfg;
  logic clear;
  cmd_t cmd;

  // coefficient registers; a write to a known register also drops the filter history
  scf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (clear)
  );

  // sequencer: gain product, pole product, lowpass add, all-pass forward
  // product, all-pass add, all-pass feedback product, state and output update
  scf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // both channels run in lockstep; the crossfeed swaps all-pass outputs at the end
  scf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .clear     (clear),
    .left_in   (left_in),
    .right_in  (right_in),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

@@ verif/crossfeed_checker.sv @@
// Checker for the stereo crossfeed: predicts each output pair and compares it
module crossfeed_checker import scf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  sample_t              left_in,
  input  sample_t              right_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  sample_t              left_out,
  input  sample_t              right_out,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // predictor copy of the coefficients and filter states
  logic        [GAIN_BITS-1:0] gain_q;
  logic        [GAIN_BITS-1:0] pole_q;
  logic signed [COEF_BITS-1:0] coef_q;
  longint lp_left, lp_right, ap_left, ap_right;

  stereo_pair_t pending_pairs[$];
  stereo_pair_t want;
  int           fail_count = 0;

  function automatic longint clamp(input longint v);
    if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
    if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
    return v;
  endfunction

  function automatic longint qprod(input longint k, input longint x);
    return clamp((k * x) >>> Q_SHIFT);
  endfunction

  function automatic void clear_filters();
    lp_left  = 0;
    lp_right = 0;
    ap_left  = 0;
    ap_right = 0;
  endfunction

  function automatic void apply_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] data);
    case (idx)
      REG_GAIN: gain_q = data[GAIN_BITS-1:0];
      REG_POLE: pole_q = data[GAIN_BITS-1:0];
      REG_COEF: coef_q = data[COEF_BITS-1:0];
      default:  return;
    endcase
    clear_filters();
  endfunction

  function automatic stereo_pair_t crossfeed_step(input sample_t l, input sample_t r);
    stereo_pair_t res;
    longint in_l, in_r, g, p, c, lpl, lpr, apl, apr;
    in_l = longint'(l);
    in_r = longint'(r);
    g    = longint'(gain_q);
    p    = longint'(pole_q);
    c    = longint'(coef_q);
    lpl  = clamp(qprod(g, in_l) + qprod(p, lp_left));
    lpr  = clamp(qprod(g, in_r) + qprod(p, lp_right));
    lp_left  = lpl;
    lp_right = lpr;
    apl      = clamp(qprod(c, lpl) + ap_left);
    ap_left  = clamp(lpl - qprod(c, apl));
    apr      = clamp(qprod(c, lpr) + ap_right);
    ap_right = clamp(lpr - qprod(c, apr));
    res.left  = sample_t'(clamp(clamp(in_l - lpl) + apr));
    res.right = sample_t'(clamp(clamp(in_r - lpr) + apl));
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_q = '0;
      pole_q = '0;
      coef_q = '0;
      clear_filters();
      pending_pairs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr[3:2], pwdata);
      end
      if (in_valid && !in_stall) begin
        pending_pairs.push_back(crossfeed_step(left_in, right_in));
      end
      if (out_valid && !out_stall) begin
        if (pending_pairs.size() == 0) begin
          $error("unexpected output pair: left_out %0d right_out %0d", left_out, right_out);
          fail_count++;
        end else begin
          want = pending_pairs.pop_front();
          if (left_out !== want.left) begin
            $error("left_out mismatch: expected %0d, got %0d", want.left, left_out);
            fail_count++;
          end
          if (right_out !== want.right) begin
            $error("right_out mismatch: expected %0d, got %0d", want.right, right_out);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_pairs.size();
    mismatches  <= fail_count;
  end

endmodule

@@ verif/tb.sv @@
// Top of the crossfeed testbench: clock, reset, register writes, requests and verdict
module tb;
  import scf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASE_ITEMS   = 275;
  localparam int          PHASES        = 6;
  localparam logic [1:0]  REG_NONE      = 2'd3;  // unmapped index, write is dropped
  localparam logic [31:0] Q_ONE         = 32'h1000_0000;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              left_in;
  sample_t              right_in;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              left_out;
  sample_t              right_out;

  int          mismatches;
  int          outstanding;
  int          cycle_count = 0;
  int unsigned idle_pct    = 36;   // sender gap rate, percent
  int unsigned stall_pct   = 36;   // receiver stall rate, percent
  int          hold_asked  = 0;    // long hold-offs asked of the receiver
  int          hold_served = 0;    // long hold-offs the receiver has finished

  stereo_crossfeed_q28 i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
  );

  // Watch both channels and the register port, predict and compare
  crossfeed_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_in     (left_in),
    .right_in    (right_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run; the limit is many times the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        // hold the result channel so the pipeline fills and pushes back
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = hold_asked;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Write one register: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one stereo request after a random gap; return at the edge that takes it
  task automatic send_pair(input sample_t l, input sample_t r);
    while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, drain every expected pair and let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range noise, with rail values and small signals mixed in
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2:    return sample_t'(int'($urandom_range(2097152)) - 1048576);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    return 32'(int'($urandom_range(32'd536870912)) - 268435456);
  endfunction

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    left_in  = '0;
    right_in = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: zero gain means the inputs pass straight through
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(sample_t'(0), sample_t'(0));
    send_pair(sample_t'(-1), sample_t'(1));
    settle();

    // Unity gain, pole and all-pass: drive the lowpass into saturation both ways
    reg_write(REG_GAIN, Q_ONE);
    reg_write(REG_POLE, Q_ONE);
    reg_write(REG_COEF, Q_ONE);
    repeat (3) send_pair(SAMPLE_MAX, SAMPLE_MAX);
    repeat (2) send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(sample_t'(0), sample_t'(0));
    settle();

    // All-pass coefficient at -2.0, below the nominal range
    reg_write(REG_COEF, 32'h2000_0000);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    settle();

    // Write to an unmapped index: coefficients and filter states must survive
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(sample_t'(12345), sample_t'(-12345));
    settle();

    // Largest gain and coefficient codes, zero pole, with garbage in the unused upper bits
    reg_write(REG_GAIN, 32'hFFFF_FFFF);
    reg_write(REG_POLE, 32'hE000_0000);
    reg_write(REG_COEF, 32'hDFFF_FFFF);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = 36;
      stall_pct = 36;
      case (ph)
        0, 5: begin
          // realistic crossfeed settings
          reg_write(REG_GAIN, 32'($urandom_range(32'h0200_0000, 32'h0600_0000)));
          reg_write(REG_POLE, 32'($urandom_range(32'h0C00_0000, 32'h0FF0_0000)));
          reg_write(REG_COEF, pick_coef());
        end
        1: begin
          // top of every register, above the nominal ranges
          reg_write(REG_GAIN, 32'h1FFF_FFFF | ($urandom() & 32'hE000_0000));
          reg_write(REG_POLE, 32'h1FFF_FFFF);
          reg_write(REG_COEF, 32'h1FFF_FFFF | ($urandom() & 32'hC000_0000));
        end
        2: begin
          // nominal range edges; this phase also carries the long hold-off
          reg_write(REG_GAIN, Q_ONE);
          reg_write(REG_POLE, 32'h0);
          reg_write(REG_COEF, 32'(-268435456));
          idle_pct = 0;
        end
        3: begin
          // passthrough gain with a strong all-pass
          reg_write(REG_GAIN, 32'h0);
          reg_write(REG_POLE, Q_ONE);
          reg_write(REG_COEF, Q_ONE);
        end
        default: begin
          // raw register words, no idling on either side
          reg_write(REG_GAIN, $urandom());
          reg_write(REG_POLE, $urandom());
          reg_write(REG_COEF, $urandom());
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 100) begin
          hold_asked = hold_asked + 1;
        end
        send_pair(pick_sample(), pick_sample());
      end
      settle();
    end

    while (hold_served != hold_asked) @(posedge clk);
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/scf_pkg.sv
hdl/scf_regs.sv
hdl/scf_ctrl.sv
hdl/scf_dp.sv
hdl/stereo_crossfeed_q28.sv
verif/crossfeed_checker.sv
verif/tb.sv
